[rtl/servo_drive_state_controller_core_assert.svh]
// Assertion macros shared by the servo drive state controller RTL.
`ifndef SERVO_DRIVE_STATE_CONTROLLER_CORE_ASSERT_SVH
`define SERVO_DRIVE_STATE_CONTROLLER_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SDSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sdsc_pkg.sv]
// Package with types, codes and constants of the servo drive state controller.
package sdsc_pkg;

    localparam int DATA_W     = 32;
    localparam int SW_W       = 16;
    localparam int REQ_W      = 3;
    localparam int CW_W       = 8;
    localparam int MODE_W     = 4;
    localparam int STATE_W    = 4;
    localparam int CMODE_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam int HALF_W     = 16;

    typedef enum logic [STATE_W-1:0] {
        DS_NOT_READY   = 4'd0,
        DS_SO_DISABLED = 4'd1,
        DS_READY       = 4'd2,
        DS_SWITCHED_ON = 4'd3,
        DS_OP_ENABLED  = 4'd4,
        DS_QUICK_STOP  = 4'd5,
        DS_FAULT_REACT = 4'd6,
        DS_FAULT       = 4'd7,
        DS_INVALID     = 4'd8
    } t_drive_state;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK         = 3'd0,
        REQ_ENABLE       = 3'd1,
        REQ_DISABLE      = 3'd2,
        REQ_BEGIN_HOMING = 3'd3,
        REQ_FORCE_HOMED  = 3'd4,
        REQ_RESET_FAULT  = 3'd5
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_MODE      = 1'd0,
        CFG_HOMING_REQUIRED = 1'd1
    } t_cfg_reg;

    localparam logic [CMODE_W-1:0] CM_POSITION = 2'd0;
    localparam logic [CMODE_W-1:0] CM_CURRENT  = 2'd2;

    localparam logic [CW_W-1:0] CW_NONE      = 8'h00;
    localparam logic [CW_W-1:0] CW_SHUTDOWN  = 8'h06;
    localparam logic [CW_W-1:0] CW_SWITCH_ON = 8'h07;
    localparam logic [CW_W-1:0] CW_ENABLE_OP = 8'h0F;
    localparam logic [CW_W-1:0] CW_FAULT_RST = 8'h80;
    localparam logic [CW_W-1:0] CW_HOMING_GO = 8'h10;

    localparam logic [MODE_W-1:0] MODE_NONE   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_HOMING = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BASE   = 4'd8;

    localparam logic [SW_W-1:0] SW_HOMING_MASK = 16'h3400;
    localparam logic [SW_W-1:0] SW_HOME_FOUND  = 16'h1400;

    localparam logic [7:0] SW_MASK_A = 8'h4F;
    localparam logic [7:0] SW_MASK_B = 8'h6F;
    localparam logic [7:0] SW_PAT_NOT_READY   = 8'h00;
    localparam logic [7:0] SW_PAT_SO_DISABLED = 8'h40;
    localparam logic [7:0] SW_PAT_READY       = 8'h21;
    localparam logic [7:0] SW_PAT_SWITCHED_ON = 8'h23;
    localparam logic [7:0] SW_PAT_OP_ENABLED  = 8'h27;
    localparam logic [7:0] SW_PAT_QUICK_STOP  = 8'h07;
    localparam logic [7:0] SW_PAT_FAULT_REACT = 8'h0F;
    localparam logic [7:0] SW_PAT_FAULT       = 8'h08;

    typedef struct packed {
        t_drive_state state;
        logic         home_found;
    } t_decode;

endpackage

[rtl/sdsc_in_if.sv]
// Input channel interface carrying one drive cycle or request transaction.
interface sdsc_in_if;
    import sdsc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [SW_W-1:0]          status_word;
    logic signed [DATA_W-1:0] actual_position;
    logic signed [DATA_W-1:0] command_value;
    logic                     command_new;

    modport source (
        output valid, req_type, status_word, actual_position, command_value, command_new,
        input  ready
    );

    modport sink (
        input  valid, req_type, status_word, actual_position, command_value, command_new,
        output ready
    );
endinterface

[rtl/sdsc_out_if.sv]
// Output channel interface carrying one result transaction.
interface sdsc_out_if;
    import sdsc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CW_W-1:0]          control_word;
    logic [MODE_W-1:0]        mode_of_operation;
    logic signed [DATA_W-1:0] command_out;
    logic                     command_write;
    logic                     reply;
    logic [STATE_W-1:0]       drive_state;
    logic                     homed;

    modport source (
        output valid, control_word, mode_of_operation, command_out, command_write,
               reply, drive_state, homed,
        input  ready
    );

    modport sink (
        input  valid, control_word, mode_of_operation, command_out, command_write,
               reply, drive_state, homed,
        output ready
    );
endinterface

[rtl/sdsc_status_decode.sv]
// Statusword decoder giving the drive power state and the homing done flag.
module sdsc_status_decode (
    input  logic [sdsc_pkg::SW_W-1:0] i_status_word,
    output sdsc_pkg::t_decode         o_decode
);
    import sdsc_pkg::*;

    logic [7:0] w_a;
    logic [7:0] w_b;

    assign w_a = i_status_word[7:0] & SW_MASK_A;
    assign w_b = i_status_word[7:0] & SW_MASK_B;

    always_comb begin
        if (w_a == SW_PAT_NOT_READY) begin
            o_decode.state = DS_NOT_READY;
        end else if (w_a == SW_PAT_SO_DISABLED) begin
            o_decode.state = DS_SO_DISABLED;
        end else if (w_b == SW_PAT_READY) begin
            o_decode.state = DS_READY;
        end else if (w_b == SW_PAT_SWITCHED_ON) begin
            o_decode.state = DS_SWITCHED_ON;
        end else if (w_b == SW_PAT_OP_ENABLED) begin
            o_decode.state = DS_OP_ENABLED;
        end else if (w_b == SW_PAT_QUICK_STOP) begin
            o_decode.state = DS_QUICK_STOP;
        end else if (w_a == SW_PAT_FAULT_REACT) begin
            o_decode.state = DS_FAULT_REACT;
        end else if (w_a == SW_PAT_FAULT) begin
            o_decode.state = DS_FAULT;
        end else begin
            o_decode.state = DS_INVALID;
        end
        o_decode.home_found = ((i_status_word & SW_HOMING_MASK) == SW_HOME_FOUND);
    end
endmodule

[rtl/servo_drive_state_controller_core.sv]
// Servo drive state controller: master side of a drive power state machine.
// Each transaction on the input channel is either a cycle tick, carrying the
// drive statusword, actual position and an optional new setpoint, or a
// request (enable, disable, begin homing, force homed, reset fault). Every
// transaction produces exactly one result with the controlword, mode of
// operation, gated setpoint, reply bit, decoded drive state and homed flag.
// A transaction is accepted on any cycle in which the result register is
// empty or its result is being taken, so one transaction per clock is
// sustained. The rate is set by the single state update loop through the
// decoder and controlword logic. Configuration must be written while no
// transaction is in flight; the block itself does not enforce this.
module servo_drive_state_controller_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sdsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sdsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sdsc_in_if.sink                         i_in,
    sdsc_out_if.source                      o_out
);
    import sdsc_pkg::*;

    `include "servo_drive_state_controller_core_assert.svh"

    logic [CMODE_W-1:0] r_drive_mode;
    t_drive_state       r_state,  n_state;
    logic               r_enable_wanted, n_enable_wanted;
    logic               r_homing_active, n_homing_active;
    logic               r_homing_complete, n_homing_complete;
    logic               r_fault_reset_pending, n_fault_reset_pending;

    logic                     r_out_valid;
    logic [CW_W-1:0]          r_cw,    n_cw;
    logic [MODE_W-1:0]        r_mode,  n_mode;
    logic signed [DATA_W-1:0] r_cmd,   n_cmd;
    logic                     r_wr,    n_wr;
    logic                     r_reply, n_reply;

    t_decode            w_dec;
    logic [CMODE_W-1:0] w_mode_sel;
    logic               w_in_acc;

    sdsc_status_decode u_decode (
        .i_status_word (i_in.status_word),
        .o_decode      (w_dec)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_mode_sel = (r_drive_mode > CM_CURRENT) ? CM_CURRENT : r_drive_mode;

    always_comb begin
        n_state               = r_state;
        n_enable_wanted       = r_enable_wanted;
        n_homing_active       = r_homing_active;
        n_homing_complete     = r_homing_complete;
        n_fault_reset_pending = r_fault_reset_pending;
        n_cw    = CW_NONE;
        n_mode  = MODE_NONE;
        n_cmd   = '0;
        n_wr    = 1'b0;
        n_reply = 1'b0;

        case (i_in.req_type)
            REQ_TICK: begin
                n_state = w_dec.state;
                if (r_homing_active && w_dec.home_found) begin
                    n_homing_active   = 1'b0;
                    n_homing_complete = 1'b1;
                end
                case (w_dec.state)
                    DS_NOT_READY: begin
                        n_enable_wanted = 1'b0;
                        n_cw = CW_NONE;
                    end
                    DS_SO_DISABLED: begin
                        n_enable_wanted = 1'b0;
                        n_cw = CW_SHUTDOWN;
                    end
                    DS_READY: begin
                        n_enable_wanted = 1'b0;
                        n_cw = CW_SWITCH_ON;
                    end
                    DS_SWITCHED_ON, DS_OP_ENABLED: begin
                        n_cw = r_enable_wanted ? CW_ENABLE_OP : CW_SWITCH_ON;
                    end
                    DS_QUICK_STOP, DS_FAULT_REACT: begin
                        n_enable_wanted = 1'b0;
                        n_cw = CW_NONE;
                    end
                    DS_FAULT: begin
                        n_enable_wanted = 1'b0;
                        if (r_fault_reset_pending) begin
                            n_cw = CW_FAULT_RST;
                            n_fault_reset_pending = 1'b0;
                        end else begin
                            n_cw = CW_NONE;
                        end
                    end
                    default: begin
                        n_cw = CW_NONE;
                    end
                endcase
                if (n_homing_complete) begin
                    n_mode = MODE_BASE + {{(MODE_W-CMODE_W){1'b0}}, w_mode_sel};
                end else begin
                    n_mode = MODE_HOMING;
                    if (n_homing_active) begin
                        n_cw = n_cw | CW_HOMING_GO;
                    end
                end
                if (w_dec.state != DS_OP_ENABLED || !n_homing_complete) begin
                    n_wr  = 1'b1;
                    n_cmd = (w_mode_sel == CM_POSITION) ? i_in.actual_position : '0;
                end else if (i_in.command_new) begin
                    n_wr = 1'b1;
                    if (w_mode_sel == CM_CURRENT) begin
                        n_cmd = {{(DATA_W-HALF_W){i_in.command_value[HALF_W-1]}},
                                 i_in.command_value[HALF_W-1:0]};
                    end else begin
                        n_cmd = i_in.command_value;
                    end
                end
            end
            REQ_ENABLE: begin
                if (r_state == DS_SWITCHED_ON) begin
                    n_enable_wanted = 1'b1;
                    n_reply = 1'b1;
                end
            end
            REQ_DISABLE: begin
                n_enable_wanted = 1'b0;
                n_reply = 1'b1;
            end
            REQ_BEGIN_HOMING: begin
                if (!r_homing_complete && r_state == DS_OP_ENABLED) begin
                    n_homing_active = 1'b1;
                end
                n_reply = n_homing_active;
            end
            REQ_FORCE_HOMED: begin
                if (r_state == DS_OP_ENABLED) begin
                    n_homing_complete = 1'b1;
                end
                n_reply = n_homing_complete;
            end
            REQ_RESET_FAULT: begin
                if (r_state == DS_FAULT) begin
                    n_fault_reset_pending = 1'b1;
                    n_reply = 1'b1;
                end
            end
            default: begin
                n_reply = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_mode          <= CM_POSITION;
            r_state               <= DS_NOT_READY;
            r_enable_wanted       <= 1'b0;
            r_homing_active       <= 1'b0;
            r_homing_complete     <= 1'b1;
            r_fault_reset_pending <= 1'b0;
            r_out_valid           <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_state               <= n_state;
                r_enable_wanted       <= n_enable_wanted;
                r_homing_active       <= n_homing_active;
                r_homing_complete     <= n_homing_complete;
                r_fault_reset_pending <= n_fault_reset_pending;
                r_out_valid           <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DRIVE_MODE: begin
                        r_drive_mode <= i_cfg_data[CMODE_W-1:0];
                    end
                    CFG_HOMING_REQUIRED: begin
                        r_homing_complete <= !i_cfg_data[0];
                    end
                    default: begin
                        r_drive_mode <= r_drive_mode;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cw    <= n_cw;
            r_mode  <= n_mode;
            r_cmd   <= n_cmd;
            r_wr    <= n_wr;
            r_reply <= n_reply;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.control_word      = r_cw;
    assign o_out.mode_of_operation = r_mode;
    assign o_out.command_out       = r_cmd;
    assign o_out.command_write     = r_wr;
    assign o_out.reply             = r_reply;
    assign o_out.drive_state       = r_state;
    assign o_out.homed             = r_homing_complete;

    `SDSC_ASSERT_NEXT(a_accept_fills_result, i_clk, i_rst_n, w_in_acc, r_out_valid, "accepted transaction left no result")
    `SDSC_ASSERT_SAME(a_request_result_quiet, i_clk, i_rst_n, r_out_valid && (r_mode == MODE_NONE), (r_cw == CW_NONE) && !r_wr, "request result drives controlword or setpoint")
    `SDSC_ASSERT_NEXT(a_enable_only_switched_on, i_clk, i_rst_n, w_in_acc && (i_in.req_type == REQ_ENABLE) && (r_state != DS_SWITCHED_ON), $stable(r_enable_wanted), "enable taken outside switched on state")
endmodule

[sim/sdsc_scoreboard_pkg.sv]
// Scoreboard class, item types and extra codes for the servo drive state controller testbench.
package sdsc_scoreboard_pkg;
    import sdsc_pkg::*;

    localparam logic [REQ_W-1:0]   REQ_SPARE_6    = 3'd6;
    localparam logic [REQ_W-1:0]   REQ_SPARE_7    = 3'd7;
    localparam logic [CMODE_W-1:0] CM_VELOCITY    = 2'd1;
    localparam logic [CMODE_W-1:0] CM_CURRENT_SAT = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [SW_W-1:0]          status_word;
        logic signed [DATA_W-1:0] actual_position;
        logic signed [DATA_W-1:0] command_value;
        logic                     command_new;
    } t_cycle_item;

    typedef struct packed {
        logic [CW_W-1:0]          control_word;
        logic [MODE_W-1:0]        mode_of_operation;
        logic signed [DATA_W-1:0] command_out;
        logic                     command_write;
        logic                     reply;
        logic [STATE_W-1:0]       drive_state;
        logic                     homed;
    } t_drive_result;

    class drive_ctrl_scoreboard;
        logic [CMODE_W-1:0] drive_mode;
        logic               homing_required;
        t_drive_state       drive_state;
        logic               enable_wanted;
        logic               homing_active;
        logic               homing_complete;
        logic               fault_reset_pending;
        t_drive_result      expected_results[$];
        int unsigned        mismatches;

        function void clear_to_reset();
            drive_mode          = CM_POSITION;
            homing_required     = 1'b0;
            drive_state         = DS_NOT_READY;
            enable_wanted       = 1'b0;
            homing_active       = 1'b0;
            homing_complete     = 1'b1;
            fault_reset_pending = 1'b0;
            expected_results.delete();
            mismatches          = 0;
        endfunction

        function void write_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DRIVE_MODE) begin
                drive_mode = data;
            end else begin
                homing_required = data[0];
                homing_complete = !data[0];
            end
        endfunction

        function t_drive_state decode_status(logic [SW_W-1:0] sw);
            logic [7:0] a;
            logic [7:0] b;
            a = sw[7:0] & SW_MASK_A;
            b = sw[7:0] & SW_MASK_B;
            if (a == SW_PAT_NOT_READY) return DS_NOT_READY;
            if (a == SW_PAT_SO_DISABLED) return DS_SO_DISABLED;
            if (b == SW_PAT_READY) return DS_READY;
            if (b == SW_PAT_SWITCHED_ON) return DS_SWITCHED_ON;
            if (b == SW_PAT_OP_ENABLED) return DS_OP_ENABLED;
            if (b == SW_PAT_QUICK_STOP) return DS_QUICK_STOP;
            if (a == SW_PAT_FAULT_REACT) return DS_FAULT_REACT;
            if (a == SW_PAT_FAULT) return DS_FAULT;
            return DS_INVALID;
        endfunction

        function t_drive_result predict_result(t_cycle_item it);
            t_drive_result      r;
            logic [CMODE_W-1:0] m;
            r = '0;
            m = (drive_mode > CM_CURRENT) ? CM_CURRENT : drive_mode;
            case (it.req_type)
                REQ_TICK: begin
                    drive_state = decode_status(it.status_word);
                    if (homing_active &&
                        (it.status_word & SW_HOMING_MASK) == SW_HOME_FOUND) begin
                        homing_active   = 1'b0;
                        homing_complete = 1'b1;
                    end
                    case (drive_state)
                        DS_NOT_READY: begin
                            enable_wanted  = 1'b0;
                            r.control_word = CW_NONE;
                        end
                        DS_SO_DISABLED: begin
                            enable_wanted  = 1'b0;
                            r.control_word = CW_SHUTDOWN;
                        end
                        DS_READY: begin
                            enable_wanted  = 1'b0;
                            r.control_word = CW_SWITCH_ON;
                        end
                        DS_SWITCHED_ON, DS_OP_ENABLED: begin
                            r.control_word = enable_wanted ? CW_ENABLE_OP : CW_SWITCH_ON;
                        end
                        DS_QUICK_STOP, DS_FAULT_REACT: begin
                            enable_wanted  = 1'b0;
                            r.control_word = CW_NONE;
                        end
                        DS_FAULT: begin
                            enable_wanted = 1'b0;
                            if (fault_reset_pending) begin
                                r.control_word      = CW_FAULT_RST;
                                fault_reset_pending = 1'b0;
                            end else begin
                                r.control_word = CW_NONE;
                            end
                        end
                        default: begin
                            r.control_word = CW_NONE;
                        end
                    endcase
                    if (homing_complete) begin
                        r.mode_of_operation = MODE_BASE + {2'b00, m};
                    end else begin
                        r.mode_of_operation = MODE_HOMING;
                        if (homing_active) r.control_word = r.control_word | CW_HOMING_GO;
                    end
                    if (drive_state != DS_OP_ENABLED || !homing_complete) begin
                        r.command_write = 1'b1;
                        r.command_out   = (m == CM_POSITION) ? it.actual_position : '0;
                    end else if (it.command_new) begin
                        r.command_write = 1'b1;
                        if (m == CM_CURRENT) begin
                            r.command_out = {{HALF_W{it.command_value[HALF_W-1]}},
                                             it.command_value[HALF_W-1:0]};
                        end else begin
                            r.command_out = it.command_value;
                        end
                    end
                end
                REQ_ENABLE: begin
                    if (drive_state == DS_SWITCHED_ON) begin
                        enable_wanted = 1'b1;
                        r.reply       = 1'b1;
                    end
                end
                REQ_DISABLE: begin
                    enable_wanted = 1'b0;
                    r.reply       = 1'b1;
                end
                REQ_BEGIN_HOMING: begin
                    if (!homing_complete && drive_state == DS_OP_ENABLED) homing_active = 1'b1;
                    r.reply = homing_active;
                end
                REQ_FORCE_HOMED: begin
                    if (drive_state == DS_OP_ENABLED) homing_complete = 1'b1;
                    r.reply = homing_complete;
                end
                REQ_RESET_FAULT: begin
                    if (drive_state == DS_FAULT) begin
                        fault_reset_pending = 1'b1;
                        r.reply             = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            r.drive_state = drive_state;
            r.homed       = homing_complete;
            return r;
        endfunction

        function void note_transaction(t_cycle_item it);
            expected_results.push_back(predict_result(it));
        endfunction

        function void check_result(t_drive_result got);
            t_drive_result exp;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result with no transaction waiting: cw=%0h mode=%0d cmd=%0h",
                             got.control_word, got.mode_of_operation, got.command_out);
                end
                return;
            end
            exp = expected_results.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result mismatch at %0t:", $realtime);
                    $display("  control_word      exp %0h got %0h",
                             exp.control_word, got.control_word);
                    $display("  mode_of_operation exp %0d got %0d",
                             exp.mode_of_operation, got.mode_of_operation);
                    $display("  command_out       exp %0h got %0h",
                             exp.command_out, got.command_out);
                    $display("  command_write     exp %0b got %0b",
                             exp.command_write, got.command_write);
                    $display("  reply             exp %0b got %0b", exp.reply, got.reply);
                    $display("  drive_state       exp %0d got %0d",
                             exp.drive_state, got.drive_state);
                    $display("  homed             exp %0b got %0b", exp.homed, got.homed);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

[sim/servo_drive_state_controller_core_tb.sv]
// Testbench for the servo drive state controller with directed and random cycle traffic.
module servo_drive_state_controller_core_tb;
    import sdsc_pkg::*;
    import sdsc_scoreboard_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sdsc_in_if  cyc_if();
    sdsc_out_if res_if();

    bit                   quiet;
    int                   walk_state;
    drive_ctrl_scoreboard sb;

    servo_drive_state_controller_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (cyc_if),
        .o_out       (res_if)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin : result_sink
        t_drive_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.control_word      = res_if.control_word;
            got.mode_of_operation = res_if.mode_of_operation;
            got.command_out       = res_if.command_out;
            got.command_write     = res_if.command_write;
            got.reply             = res_if.reply;
            got.drive_state       = res_if.drive_state;
            got.homed             = res_if.homed;
            sb.check_result(got);
        end
        res_if.ready <= quiet || ($urandom_range(0, 99) >= 21);
    end

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [SW_W-1:0] sw,
                             input logic [DATA_W-1:0] pos, input logic [DATA_W-1:0] cmd,
                             input logic fresh);
        t_cycle_item it;
        it.req_type        = req;
        it.status_word     = sw;
        it.actual_position = pos;
        it.command_value   = cmd;
        it.command_new     = fresh;
        while (!quiet && $urandom_range(0, 99) < 21) begin
            cyc_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cyc_if.valid           <= 1'b1;
        cyc_if.req_type        <= req;
        cyc_if.status_word     <= sw;
        cyc_if.actual_position <= pos;
        cyc_if.command_value   <= cmd;
        cyc_if.command_new     <= fresh;
        @(posedge i_clk);
        while (!cyc_if.ready) @(posedge i_clk);
        sb.note_transaction(it);
    endtask

    task automatic drain_results();
        cyc_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_register(idx, data);
    endtask

    task automatic set_config(input logic [CMODE_W-1:0] cm, input logic hr);
        drain_results();
        write_cfg(CFG_DRIVE_MODE, cm);
        write_cfg(CFG_HOMING_REQUIRED, {1'($urandom_range(0, 1)), hr});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SW_W-1:0] status_for(int s);
        logic [SW_W-1:0] w;
        w = SW_W'($urandom);
        case (s)
            DS_NOT_READY:   w[7:0] = (w[7:0] & ~SW_MASK_A) | SW_PAT_NOT_READY;
            DS_SO_DISABLED: w[7:0] = (w[7:0] & ~SW_MASK_A) | SW_PAT_SO_DISABLED;
            DS_READY:       w[7:0] = (w[7:0] & ~SW_MASK_B) | SW_PAT_READY;
            DS_SWITCHED_ON: w[7:0] = (w[7:0] & ~SW_MASK_B) | SW_PAT_SWITCHED_ON;
            DS_OP_ENABLED:  w[7:0] = (w[7:0] & ~SW_MASK_B) | SW_PAT_OP_ENABLED;
            DS_QUICK_STOP:  w[7:0] = (w[7:0] & ~SW_MASK_B) | SW_PAT_QUICK_STOP;
            DS_FAULT_REACT: w[7:0] = (w[7:0] & ~SW_MASK_A) | SW_PAT_FAULT_REACT;
            DS_FAULT:       w[7:0] = (w[7:0] & ~SW_MASK_A) | SW_PAT_FAULT;
            default:        w[7:0] = {w[7], 2'b00, w[4], 4'b0001};
        endcase
        if ($urandom_range(0, 5) == 0) begin
            w[13] = 1'b0;
            w[12] = 1'b1;
            w[10] = 1'b1;
        end
        return w;
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            send_item(REQ_TICK,
                      ($urandom_range(0, 9) == 0) ? SW_W'($urandom) : status_for(walk_state),
                      $urandom, $urandom, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                if (walk_state < DS_OP_ENABLED) begin
                    walk_state = walk_state + 1;
                end else if (walk_state == DS_OP_ENABLED) begin
                    walk_state = $urandom_range(DS_NOT_READY, DS_INVALID);
                end else begin
                    walk_state = $urandom_range(0, 1) ? DS_SO_DISABLED : DS_FAULT;
                end
            end
        end else if (r < 92) begin
            send_item(REQ_W'($urandom_range(REQ_ENABLE, REQ_RESET_FAULT)), SW_W'($urandom),
                      $urandom, $urandom, 1'($urandom_range(0, 1)));
        end else begin
            send_item(REQ_W'($urandom_range(REQ_TICK, REQ_SPARE_7)), SW_W'($urandom),
                      $urandom, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        sb = new;
        sb.clear_to_reset();
        quiet                  = 1'b0;
        walk_state             = DS_NOT_READY;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_index            = CFG_DRIVE_MODE;
        i_cfg_data             = '0;
        cyc_if.valid           = 1'b0;
        cyc_if.req_type        = REQ_TICK;
        cyc_if.status_word     = '0;
        cyc_if.actual_position = '0;
        cyc_if.command_value   = '0;
        cyc_if.command_new     = 1'b0;
        res_if.ready           = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(REQ_TICK, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_item(REQ_TICK, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_item(REQ_TICK, 16'h0040, 32'h0000_0001, 32'h0000_0000, 1'b0);
        send_item(REQ_ENABLE, 16'h0000, 32'h0, 32'h0, 1'b0);
        send_item(REQ_TICK, 16'h0021, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_item(REQ_TICK, 16'h0023, 32'h1234_5678, 32'h0, 1'b1);
        send_item(REQ_ENABLE, 16'hFFFF, 32'h0, 32'h0, 1'b1);
        send_item(REQ_TICK, 16'h0027, 32'h0000_0010, 32'h8000_0000, 1'b1);
        send_item(REQ_TICK, 16'hFFA7, 32'h0000_0010, 32'h7FFF_FFFF, 1'b0);
        send_item(REQ_BEGIN_HOMING, 16'h0, 32'h0, 32'h0, 1'b0);
        send_item(REQ_FORCE_HOMED, 16'h0, 32'h0, 32'h0, 1'b0);
        send_item(REQ_DISABLE, 16'h0, 32'h0, 32'h0, 1'b0);
        send_item(REQ_TICK, 16'h0007, 32'h8000_0000, 32'h0, 1'b0);
        send_item(REQ_TICK, 16'h000F, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_item(REQ_TICK, 16'h0008, 32'h0, 32'h0, 1'b0);
        send_item(REQ_RESET_FAULT, 16'h0, 32'h0, 32'h0, 1'b0);
        send_item(REQ_TICK, 16'h0008, 32'h0, 32'h0, 1'b0);
        send_item(REQ_SPARE_6, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(REQ_SPARE_7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(REQ_TICK, 16'h0001, 32'h0, 32'h0, 1'b0);

        set_config(CM_CURRENT, 1'b1);
        send_item(REQ_TICK, 16'h0023, 32'h0000_0055, 32'h0, 1'b0);
        send_item(REQ_ENABLE, 16'h0, 32'h0, 32'h0, 1'b0);
        send_item(REQ_TICK, 16'h0027, 32'h0000_0055, 32'h0001_8000, 1'b1);
        send_item(REQ_BEGIN_HOMING, 16'h0, 32'h0, 32'h0, 1'b0);
        send_item(REQ_TICK, 16'h0027, 32'h0000_0055, 32'h0, 1'b0);
        send_item(REQ_TICK, 16'h1427, 32'h0000_0055, 32'h0, 1'b0);
        send_item(REQ_TICK, 16'h0027, 32'h0000_0055, 32'h0001_8000, 1'b1);
        send_item(REQ_TICK, 16'h0027, 32'h0000_0055, 32'h7FFF_7FFF, 1'b1);

        for (int phase = 0; phase < 12; phase++) begin
            set_config(CMODE_W'(phase % 4), 1'((phase / 4) % 2));
            quiet      = (phase == 5);
            walk_state = DS_SO_DISABLED;
            for (int n = 0; n < 100; n++) random_item();
        end
        quiet = 1'b0;

        drain_results();
        repeat (5) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
